// ===== sv/dur_pkg.sv =====
// Shared types, register indexes and helpers for the dual ultrasonic ranger.
// No dependencies; every design file of the block imports this package.
`timescale 1ns / 1ps

package dur_pkg;

    // Width of the tick counter and of the captured edge times
    localparam int TIME_BITS = 16;
    // Width used for phase-length compares (holds either operand plus one)
    localparam int CMP_BITS  = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

    localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};

    // Configuration register indexes
    localparam int IDX_BITS = 3;
    localparam logic [IDX_BITS-1:0] REG_TRIGGER_WIDTH = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_LISTEN_WINDOW = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_GAP_WINDOW    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_SCALE_Q16     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_DISTANCE_CAP  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_REPORT_ENABLE = 3'd5;

    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_LISTEN  = 2'd1,
        PH_GAP     = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  trigger_width;
        logic [15:0] listen_window;
        logic [15:0] gap_window;
        logic [15:0] scale_q16;
        logic [7:0]  distance_cap;
        logic        report_enable;
    } cfg_t;

    typedef struct packed {
        logic       trig_front;
        logic       trig_back;
        logic       report_valid;
        logic       report_sensor;
        logic [7:0] report_distance;
    } result_t;

    // True on the last tick of a phase that lasts len ticks
    function automatic logic phase_done(logic [TIME_BITS-1:0] tick, logic [15:0] len);
        logic [CMP_BITS-1:0] tick_ext;
        logic [CMP_BITS-1:0] len_ext;
        tick_ext = {{(CMP_BITS - TIME_BITS){1'b0}}, tick};
        len_ext  = {{(CMP_BITS - 16){1'b0}}, len};
        return ((tick_ext + 1'b1) >= len_ext) || (tick == TICK_MAX);
    endfunction

endpackage

// ===== sv/dur_cfg_regs.sv =====
// Configuration register file of the dual ultrasonic ranger.
// Depends on dur_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module dur_cfg_regs
    import dur_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field; other indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TRIGGER_WIDTH: cfg_next.trigger_width = cfg_data[7:0];
                REG_LISTEN_WINDOW: cfg_next.listen_window = cfg_data;
                REG_GAP_WINDOW:    cfg_next.gap_window    = cfg_data;
                REG_SCALE_Q16:     cfg_next.scale_q16     = cfg_data;
                REG_DISTANCE_CAP:  cfg_next.distance_cap  = cfg_data[7:0];
                REG_REPORT_ENABLE: cfg_next.report_enable = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width <= 8'd10;
            cfg_reg.listen_window <= 16'd25000;
            cfg_reg.gap_window    <= 16'd25000;
            cfg_reg.scale_q16     <= 16'd1114;
            cfg_reg.distance_cap  <= 8'd200;
            cfg_reg.report_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/dur_measure.sv =====
// Echo width to distance conversion: scale, round, cap, and no-echo handling.
// Depends on dur_pkg for TIME_BITS.
`timescale 1ns / 1ps

module dur_measure
    import dur_pkg::*;
(
    input  logic                 start_seen,
    input  logic                 end_seen,
    input  logic [TIME_BITS-1:0] start_time,
    input  logic [TIME_BITS-1:0] end_time,
    input  logic [15:0]          scale_q16,
    input  logic [7:0]           distance_cap,
    output logic [7:0]           distance
);

    logic [TIME_BITS-1:0]    echo_width;
    logic [TIME_BITS+15:0]   product;
    logic [TIME_BITS+15:0]   rounded;
    logic [TIME_BITS-1:0]    scaled;
    logic [7:0]              none_code;

    // Width in ticks, wrapping at the counter size
    assign echo_width = end_time - start_time;
    assign product    = echo_width * scale_q16;
    // Round half up before dropping the 16 fraction bits
    assign rounded    = product + {{TIME_BITS{1'b0}}, 16'h8000};
    assign scaled     = rounded[TIME_BITS+15:16];

    // Cap plus one, saturated at the top code
    assign none_code  = (distance_cap == 8'hFF) ? 8'hFF : distance_cap + 8'd1;

    always_comb
    begin
        if (!start_seen || !end_seen)
            distance = none_code;
        else if (scaled > {{(TIME_BITS - 8){1'b0}}, distance_cap})
            distance = none_code;
        else
            distance = scaled[7:0];
    end

endmodule

// ===== sv/dur_sequencer.sv =====
// Trigger / listen / gap sequencer with echo edge capture, one tick per step.
// Depends on dur_pkg and dur_measure.
`timescale 1ns / 1ps

module dur_sequencer
    import dur_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    echo_front,
    input  logic    echo_back,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t               phase_reg,      phase_next;
    logic [TIME_BITS-1:0] tick_reg,       tick_next;
    logic                 sensor_reg,     sensor_next;
    logic                 echo_prev_reg,  echo_prev_next;
    logic                 start_seen_reg, start_seen_next;
    logic [TIME_BITS-1:0] start_time_reg, start_time_next;
    logic                 end_seen_reg,   end_seen_next;
    logic [TIME_BITS-1:0] end_time_reg,   end_time_next;

    // Edge capture values of this tick, fed to the distance math
    logic                 cap_start_seen;
    logic [TIME_BITS-1:0] cap_start_time;
    logic                 cap_end_seen;
    logic [TIME_BITS-1:0] cap_end_time;
    logic                 echo;
    logic                 echo_edge;
    logic [TIME_BITS-1:0] tick_inc;
    logic [7:0]           distance;

    assign echo      = sensor_reg ? echo_back : echo_front;
    assign echo_edge = (echo != echo_prev_reg);
    assign tick_inc  = tick_reg + 1'b1;

    // First edge marks the start, every later edge moves the end
    always_comb
    begin
        cap_start_seen = start_seen_reg;
        cap_start_time = start_time_reg;
        cap_end_seen   = end_seen_reg;
        cap_end_time   = end_time_reg;
        if (echo_edge)
        begin
            if (!start_seen_reg)
            begin
                cap_start_seen = 1'b1;
                cap_start_time = tick_reg;
            end
            else
            begin
                cap_end_seen = 1'b1;
                cap_end_time = tick_reg;
            end
        end
    end

    dur_measure u_measure (
        .start_seen   (cap_start_seen),
        .end_seen     (cap_end_seen),
        .start_time   (cap_start_time),
        .end_time     (cap_end_time),
        .scale_q16    (cfg.scale_q16),
        .distance_cap (cfg.distance_cap),
        .distance     (distance)
    );

    // Next state and result of the current tick
    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_inc;
        sensor_next     = sensor_reg;
        echo_prev_next  = echo_prev_reg;
        start_seen_next = start_seen_reg;
        start_time_next = start_time_reg;
        end_seen_next   = end_seen_reg;
        end_time_next   = end_time_reg;
        result          = '0;

        case (phase_reg)
            PH_LISTEN:
            begin
                echo_prev_next  = echo;
                start_seen_next = cap_start_seen;
                start_time_next = cap_start_time;
                end_seen_next   = cap_end_seen;
                end_time_next   = cap_end_time;
                if (phase_done(tick_reg, cfg.listen_window))
                begin
                    if (cfg.report_enable)
                    begin
                        result.report_valid    = 1'b1;
                        result.report_sensor   = sensor_reg;
                        result.report_distance = distance;
                    end
                    start_seen_next = 1'b0;
                    end_seen_next   = 1'b0;
                    start_time_next = '0;
                    end_time_next   = '0;
                    tick_next       = '0;
                    if (cfg.gap_window == 16'd0)
                    begin
                        sensor_next = ~sensor_reg;
                        phase_next  = PH_TRIGGER;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                    end
                end
            end
            PH_GAP:
            begin
                if (phase_done(tick_reg, cfg.gap_window))
                begin
                    tick_next   = '0;
                    sensor_next = ~sensor_reg;
                    phase_next  = PH_TRIGGER;
                end
            end
            default:
            begin
                // Trigger phase; an unknown code behaves the same way
                result.trig_front = ~sensor_reg;
                result.trig_back  = sensor_reg;
                if (phase_done(tick_reg, {8'd0, cfg.trigger_width}))
                begin
                    tick_next       = '0;
                    echo_prev_next  = 1'b0;
                    start_seen_next = 1'b0;
                    end_seen_next   = 1'b0;
                    phase_next      = PH_LISTEN;
                end
            end
        endcase
    end

    // Advance the state only when a tick word moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TRIGGER;
            tick_reg       <= '0;
            sensor_reg     <= 1'b0;
            echo_prev_reg  <= 1'b0;
            start_seen_reg <= 1'b0;
            start_time_reg <= '0;
            end_seen_reg   <= 1'b0;
            end_time_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            sensor_reg     <= sensor_next;
            echo_prev_reg  <= echo_prev_next;
            start_seen_reg <= start_seen_next;
            start_time_reg <= start_time_next;
            end_seen_reg   <= end_seen_next;
            end_time_reg   <= end_time_next;
        end
    end

endmodule

// ===== sv/dual_ultrasonic_ranger.sv =====
// Dual ultrasonic ranger: serves a front and a back echo sensor in turn, one
// microsecond tick per input word, and gives one result word per tick (trigger
// levels and, on the last listen tick with reports on, the measured distance).
// It takes a new tick word every clock cycle while in_stall is low; each result
// passes through an input register, a single-pass sequencer and the result
// register. The rate is set by the sequencer, which retires one tick per cycle
// unless stalled, with the width multiply, rounding and cap check in that same
// pass. A stall on the result side holds the result register and then backs up
// one more word in the input register before in_stall rises. No clearing after
// reset. Depends on dur_pkg, dur_cfg_regs, dur_sequencer and dur_measure.
`timescale 1ns / 1ps

module dual_ultrasonic_ranger
    import dur_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Tick words
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     echo_front,
    input  logic                     echo_back,
    // Result words
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     trig_front,
    output logic                     trig_back,
    output logic                     report_valid,
    output logic                     report_sensor,
    output logic [7:0]               report_distance,
    // Configuration writes
    input  logic                     cfg_write,
    input  logic [IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg;
    result_t step_result;
    result_t res_reg;

    logic    a_valid_reg, a_valid_next;
    logic    a_front_reg;
    logic    a_back_reg;
    logic    out_valid_reg, out_valid_next;
    logic    res_free;
    logic    step;
    logic    in_take;

    dur_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dur_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .echo_front (a_front_reg),
        .echo_back  (a_back_reg),
        .cfg        (cfg),
        .result     (step_result)
    );

    // Handshake: the result register frees when empty or being taken
    assign res_free = !out_valid_reg || !out_stall;
    assign step     = a_valid_reg && res_free;
    assign in_stall = a_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_take)
            a_valid_next = 1'b1;
        else if (step)
            a_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the tick word until the sequencer takes it
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_front_reg <= echo_front;
            a_back_reg  <= echo_back;
        end
    end

    // Load the result word as the tick retires
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= step_result;
    end

    assign out_valid       = out_valid_reg;
    assign trig_front      = res_reg.trig_front;
    assign trig_back       = res_reg.trig_back;
    assign report_valid    = res_reg.report_valid;
    assign report_sensor   = res_reg.report_sensor;
    assign report_distance = res_reg.report_distance;

endmodule

// ===== sv/dur_checker.sv =====
// Port-level checks for the dual ultrasonic ranger, bound to the top level.
// Depends only on the port names of dual_ultrasonic_ranger.
`timescale 1ns / 1ps

module dur_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       trig_front,
    input logic       trig_back,
    input logic       report_valid,
    input logic       report_sensor,
    input logic [7:0] report_distance
);

    // Only one sensor is ever triggered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(trig_front && trig_back))
        else $error("both triggers driven in one word");

    // A report comes from the listen phase, never while triggering
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_valid) |-> (!trig_front && !trig_back))
        else $error("report given during a trigger word");

    // Report fields are zero when no report is given
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !report_valid) |-> (!report_sensor && report_distance == 8'd0))
        else $error("report fields set without a report");

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(report_distance)
            && $stable(report_valid) && $stable(trig_front) && $stable(trig_back)))
        else $error("stalled result word changed");

    // The input backs up only behind a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with the result side free");

endmodule

bind dual_ultrasonic_ranger dur_checker u_dur_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .trig_front      (trig_front),
    .trig_back       (trig_back),
    .report_valid    (report_valid),
    .report_sensor   (report_sensor),
    .report_distance (report_distance)
);
